>>> rtl/core/vmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector magnitude clamp package
// Widths, stage counts, register map and payload types shared by the block.
// ----------------------------------------------------------------------------
package vmc_pkg;

    localparam int CW          = 32;
    localparam int NCOMP       = 4;
    localparam int LEN_W       = CW + 1;
    localparam int BOUND_W     = CW - 1;
    localparam int SQ_W        = 2 * CW;
    localparam int SUM_W       = 2 * CW + 2;
    localparam int REM_W       = LEN_W + 4;
    localparam int SQRT_STAGES = SUM_W / 2;
    localparam int PROD_W      = CW + BOUND_W - 1;
    localparam int DIV_STAGES  = CW - 1;
    localparam int DREM_W      = LEN_W + 1;
    localparam int LATENCY     = 7 + SQRT_STAGES + DIV_STAGES;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = 2;
    localparam int ADDR_W      = 4;

    localparam logic [1:0] REG_DIMENSION  = 2'd0;
    localparam logic [1:0] REG_MIN_LENGTH = 2'd1;
    localparam logic [1:0] REG_MAX_LENGTH = 2'd2;

    localparam logic [2:0]         DIMENSION_RESET = 3'd4;
    localparam logic [BOUND_W-1:0] MIN_RESET       = '0;
    localparam logic [BOUND_W-1:0] MAX_RESET       = '1;

    typedef struct packed {
        logic signed [CW-1:0] comp_x;
        logic signed [CW-1:0] comp_y;
        logic signed [CW-1:0] comp_z;
        logic signed [CW-1:0] comp_w;
    } vec_in_t;

    typedef struct packed {
        logic signed [CW-1:0] out_x;
        logic signed [CW-1:0] out_y;
        logic signed [CW-1:0] out_z;
        logic signed [CW-1:0] out_w;
    } vec_out_t;

    typedef struct packed {
        logic [2:0]         dimension;
        logic [BOUND_W-1:0] min_length;
        logic [BOUND_W-1:0] max_length;
    } cfg_t;

    typedef struct packed {
        logic [NCOMP-1:0][CW-1:0] raw;
        logic [NCOMP-1:0][CW-1:0] mag;
        logic [NCOMP-1:0]         neg;
        logic [LEN_W-1:0]         len;
        logic [BOUND_W-1:0]       bound;
        logic                     pass;
    } job_t;

endpackage

>>> rtl/core/vmc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector magnitude clamp front end
// Masks unused components, sums squares, takes the root one bit per stage
// and classifies each vector as pass-through or rescale.
// ----------------------------------------------------------------------------
module vmc_front
    import vmc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    accept,
    input  vec_in_t operand,
    output logic    push,
    output job_t    push_job
);

    logic [NCOMP-1:0][CW-1:0] in_raw;
    logic [NCOMP-1:0][CW-1:0] in_mag;
    logic [NCOMP-1:0]         in_neg;
    logic                     use_z;
    logic                     use_w;

    logic                     a_valid_reg;
    logic [NCOMP-1:0][CW-1:0] a_raw_reg;
    logic [NCOMP-1:0][CW-1:0] a_mag_reg;
    logic [NCOMP-1:0]         a_neg_reg;

    logic                     b_valid_reg;
    logic [NCOMP-1:0][CW-1:0] b_raw_reg;
    logic [NCOMP-1:0][CW-1:0] b_mag_reg;
    logic [NCOMP-1:0]         b_neg_reg;
    logic [NCOMP-1:0][SQ_W-1:0] b_sq_reg;

    logic                     s_valid_reg [0:SQRT_STAGES];
    logic [SUM_W-1:0]         s_rad_reg   [0:SQRT_STAGES];
    logic [REM_W-1:0]         s_rem_reg   [0:SQRT_STAGES];
    logic [LEN_W-1:0]         s_root_reg  [0:SQRT_STAGES];
    logic [NCOMP-1:0][CW-1:0] s_raw_reg   [0:SQRT_STAGES];
    logic [NCOMP-1:0][CW-1:0] s_mag_reg   [0:SQRT_STAGES];
    logic [NCOMP-1:0]         s_neg_reg   [0:SQRT_STAGES];

    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] min_ext;
    logic [LEN_W-1:0] max_ext;

    assign use_z = (cfg.dimension >= 3'd3);
    assign use_w = (cfg.dimension >= 3'd4);

    always_comb
    begin
        in_raw[0] = operand.comp_x;
        in_raw[1] = operand.comp_y;
        in_raw[2] = use_z ? operand.comp_z : '0;
        in_raw[3] = use_w ? operand.comp_w : '0;
        for (int i = 0; i < NCOMP; i++)
        begin
            in_neg[i] = in_raw[i][CW-1];
            in_mag[i] = in_neg[i] ? (~in_raw[i] + 1'b1) : in_raw[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
            s_valid_reg[0] <= 1'b0;
        end
        else
        begin
            a_valid_reg    <= accept;
            b_valid_reg    <= a_valid_reg;
            s_valid_reg[0] <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_raw_reg <= in_raw;
        a_mag_reg <= in_mag;
        a_neg_reg <= in_neg;
        b_raw_reg <= a_raw_reg;
        b_mag_reg <= a_mag_reg;
        b_neg_reg <= a_neg_reg;
        for (int i = 0; i < NCOMP; i++)
        begin
            b_sq_reg[i] <= a_mag_reg[i] * a_mag_reg[i];
        end
        s_rad_reg[0]  <= {2'b00, b_sq_reg[0]} + {2'b00, b_sq_reg[1]}
                       + {2'b00, b_sq_reg[2]} + {2'b00, b_sq_reg[3]};
        s_rem_reg[0]  <= '0;
        s_root_reg[0] <= '0;
        s_raw_reg[0]  <= b_raw_reg;
        s_mag_reg[0]  <= b_mag_reg;
        s_neg_reg[0]  <= b_neg_reg;
    end

    for (genvar j = 0; j < SQRT_STAGES; j++)
    begin : g_sqrt
        logic [REM_W-1:0] r2;
        logic [REM_W-1:0] trial;
        logic             ge;

        assign r2    = {s_rem_reg[j][REM_W-3:0], s_rad_reg[j][SUM_W-1 -: 2]};
        assign trial = {{(REM_W-LEN_W-2){1'b0}}, s_root_reg[j], 2'b01};
        assign ge    = (r2 >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                s_valid_reg[j+1] <= 1'b0;
            end
            else
            begin
                s_valid_reg[j+1] <= s_valid_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            s_rad_reg[j+1]  <= {s_rad_reg[j][SUM_W-3:0], 2'b00};
            s_rem_reg[j+1]  <= ge ? (r2 - trial) : r2;
            s_root_reg[j+1] <= {s_root_reg[j][LEN_W-2:0], ge};
            s_raw_reg[j+1]  <= s_raw_reg[j];
            s_mag_reg[j+1]  <= s_mag_reg[j];
            s_neg_reg[j+1]  <= s_neg_reg[j];
        end
    end

    assign len     = s_root_reg[SQRT_STAGES];
    assign min_ext = {{(LEN_W-BOUND_W){1'b0}}, cfg.min_length};
    assign max_ext = {{(LEN_W-BOUND_W){1'b0}}, cfg.max_length};

    always_comb
    begin
        push_job.raw   = s_raw_reg[SQRT_STAGES];
        push_job.mag   = s_mag_reg[SQRT_STAGES];
        push_job.neg   = s_neg_reg[SQRT_STAGES];
        push_job.len   = len;
        push_job.bound = (len < min_ext) ? cfg.min_length : cfg.max_length;
        push_job.pass  = (len == '0) || ((len >= min_ext) && (len <= max_ext));
    end

    assign push = s_valid_reg[SQRT_STAGES];

endmodule

>>> rtl/core/vmc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector magnitude clamp job queue
// Short FIFO that decouples the length front end from the rescale back end.
// ----------------------------------------------------------------------------
module vmc_queue
    import vmc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic pop_valid,
    output job_t pop_job,
    output logic full
);

    job_t                 mem [0:FIFO_DEPTH-1];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_AW:0]     count_reg;
    logic                 do_pop;

    assign pop_valid = (count_reg != '0);
    assign full      = (count_reg == FIFO_AW'(0) + (FIFO_AW+1)'(FIFO_DEPTH));
    assign do_pop    = pop && pop_valid;
    assign pop_job   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(do_pop);
        end
    end

endmodule

>>> rtl/core/vmc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector magnitude clamp divider lane
// Restoring divide of one scaled component by the length, one quotient bit
// per stage, with signed saturation at the end.
// ----------------------------------------------------------------------------
module vmc_div
    import vmc_pkg::*;
(
    input  logic                 clk,
    input  logic [PROD_W-1:0]    prod,
    input  logic [LEN_W-1:0]     len,
    input  logic                 neg,
    output logic signed [CW-1:0] scaled
);

    logic                  over_reg [0:DIV_STAGES];
    logic                  neg_reg  [0:DIV_STAGES];
    logic [LEN_W-1:0]      len_reg  [0:DIV_STAGES];
    logic [LEN_W-1:0]      rem_reg  [0:DIV_STAGES];
    logic [DIV_STAGES-1:0] low_reg  [0:DIV_STAGES];
    logic [DIV_STAGES-1:0] quo_reg  [0:DIV_STAGES];
    logic [CW-1:0]         quo_ext;

    always_ff @(posedge clk)
    begin
        over_reg[0] <= ({2'b00, prod} >= {len, {DIV_STAGES{1'b0}}});
        neg_reg[0]  <= neg;
        len_reg[0]  <= len;
        rem_reg[0]  <= {{(LEN_W-(PROD_W-DIV_STAGES)){1'b0}}, prod[PROD_W-1:DIV_STAGES]};
        low_reg[0]  <= prod[DIV_STAGES-1:0];
        quo_reg[0]  <= '0;
    end

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_step
        logic [DREM_W-1:0] r2;
        logic              ge;

        assign r2 = {rem_reg[k], low_reg[k][DIV_STAGES-1]};
        assign ge = (r2 >= {1'b0, len_reg[k]});

        always_ff @(posedge clk)
        begin
            over_reg[k+1] <= over_reg[k];
            neg_reg[k+1]  <= neg_reg[k];
            len_reg[k+1]  <= len_reg[k];
            rem_reg[k+1]  <= ge ? LEN_W'(r2 - {1'b0, len_reg[k]}) : LEN_W'(r2);
            low_reg[k+1]  <= {low_reg[k][DIV_STAGES-2:0], 1'b0};
            quo_reg[k+1]  <= {quo_reg[k][DIV_STAGES-2:0], ge};
        end
    end

    assign quo_ext = {1'b0, quo_reg[DIV_STAGES]};

    always_comb
    begin
        if (over_reg[DIV_STAGES])
        begin
            scaled = neg_reg[DIV_STAGES] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end
        else
        begin
            scaled = neg_reg[DIV_STAGES] ? (~quo_ext + 1'b1) : quo_ext;
        end
    end

endmodule

>>> rtl/core/vmc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector magnitude clamp back end
// Scales each component by the bound and divides by the length in four lanes,
// or passes the raw components through, and registers the result transaction.
// ----------------------------------------------------------------------------
module vmc_back
    import vmc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     job_valid,
    input  job_t     job,
    output logic     done,
    output vec_out_t result
);

    localparam int META_STAGES = DIV_STAGES + 1;

    logic                         p_valid_reg;
    logic [NCOMP-1:0][PROD_W-1:0] p_prod_reg;
    logic [NCOMP-1:0]             p_neg_reg;
    logic [LEN_W-1:0]             p_len_reg;
    logic [NCOMP-1:0][CW-1:0]     p_raw_reg;
    logic                         p_pass_reg;

    logic                     m_valid_reg [0:META_STAGES-1];
    logic [NCOMP-1:0][CW-1:0] m_raw_reg   [0:META_STAGES-1];
    logic                     m_pass_reg  [0:META_STAGES-1];

    logic [NCOMP-1:0][CW-1:0] lane_out;

    logic                     done_reg;
    logic [NCOMP-1:0][CW-1:0] res_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NCOMP; i++)
        begin
            p_prod_reg[i] <= PROD_W'(job.mag[i]) * PROD_W'(job.bound);
        end
        p_neg_reg  <= job.neg;
        p_len_reg  <= job.len;
        p_raw_reg  <= job.raw;
        p_pass_reg <= job.pass;
        m_raw_reg[0]  <= p_raw_reg;
        m_pass_reg[0] <= p_pass_reg;
        for (int s = 1; s < META_STAGES; s++)
        begin
            m_raw_reg[s]  <= m_raw_reg[s-1];
            m_pass_reg[s] <= m_pass_reg[s-1];
        end
        res_reg <= m_pass_reg[META_STAGES-1] ? m_raw_reg[META_STAGES-1] : lane_out;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            for (int s = 0; s < META_STAGES; s++)
            begin
                m_valid_reg[s] <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg    <= job_valid;
            m_valid_reg[0] <= p_valid_reg;
            for (int s = 1; s < META_STAGES; s++)
            begin
                m_valid_reg[s] <= m_valid_reg[s-1];
            end
            done_reg <= m_valid_reg[META_STAGES-1];
        end
    end

    for (genvar i = 0; i < NCOMP; i++)
    begin : g_lane
        vmc_div u_div (
            .clk    (clk),
            .prod   (p_prod_reg[i]),
            .len    (p_len_reg),
            .neg    (p_neg_reg[i]),
            .scaled (lane_out[i])
        );
    end

    assign done         = done_reg;
    assign result.out_x = res_reg[0];
    assign result.out_y = res_reg[1];
    assign result.out_z = res_reg[2];
    assign result.out_w = res_reg[3];

endmodule

>>> rtl/core/vector_magnitude_clamp_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector magnitude clamp
// Clamps the length of a two to four component Q16.16 vector between two
// programmable bounds while keeping its direction.
// ----------------------------------------------------------------------------
// From the accepting edge to the edge that takes the result, a transaction passes
// through the 33-stage root pipeline and the 31-stage divider lanes.
// Throughput: one transaction per cycle; every stage is pipelined and the back
// end never stalls, so busy stays low.
// Reset: rst_n clears all pipeline valids, the queue and the registers to
// dimension 4, min_length 0, max_length 0x7FFFFFFF; the result has no stall.
// ----------------------------------------------------------------------------
module vector_magnitude_clamp_top
    import vmc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  vec_in_t           operand,
    output logic              done,
    output vec_out_t          result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [2:0]         dimension_reg;
    logic [BOUND_W-1:0] min_length_reg;
    logic [BOUND_W-1:0] max_length_reg;
    cfg_t               cfg;
    logic               wr_en;
    logic               accept;
    logic               push;
    job_t               push_job;
    logic               pop_valid;
    job_t               pop_job;
    logic               full;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dimension_reg  <= DIMENSION_RESET;
            min_length_reg <= MIN_RESET;
            max_length_reg <= MAX_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_DIMENSION:  dimension_reg  <= pwdata[2:0];
                REG_MIN_LENGTH: min_length_reg <= pwdata[BOUND_W-1:0];
                REG_MAX_LENGTH: max_length_reg <= pwdata[BOUND_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_DIMENSION:  prdata = {29'b0, dimension_reg};
            REG_MIN_LENGTH: prdata = {1'b0, min_length_reg};
            REG_MAX_LENGTH: prdata = {1'b0, max_length_reg};
            default:        prdata = '0;
        endcase
    end

    assign cfg.dimension  = dimension_reg;
    assign cfg.min_length = min_length_reg;
    assign cfg.max_length = max_length_reg;

    assign busy   = full;
    assign accept = start && !busy;

    vmc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .accept   (accept),
        .operand  (operand),
        .push     (push),
        .push_job (push_job)
    );

    vmc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .pop       (1'b1),
        .pop_valid (pop_valid),
        .pop_job   (pop_job),
        .full      (full)
    );

    vmc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (pop_valid),
        .job       (pop_job),
        .done      (done),
        .result    (result)
    );

endmodule

>>> rtl/core/vmc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector magnitude clamp checker
// Port-level checks on transaction latency and result integrity.
// ----------------------------------------------------------------------------
module vmc_checker
    import vmc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input vec_out_t          result
);

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted transaction produced no result at fixed latency");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without a matching accepted transaction");

    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$isunknown(result))
        else $error("result carries unknown bits");

endmodule

bind vector_magnitude_clamp_top vmc_checker u_vmc_checker (.*);

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector magnitude clamp testbench
// Drives vectors through the command port under several register settings,
// predicts each clamped vector from its own fixed-point model and compares
// every strobed result, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    import vmc_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    vec_in_t           operand;
    logic              done;
    vec_out_t          result;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    vector_magnitude_clamp_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .operand (operand),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    vec_in_t      pending_vecs[$];
    vec_out_t     expected_vecs[$];
    logic [2:0]   cur_dim;
    logic [30:0]  cur_min;
    logic [30:0]  cur_max;
    int           errors;
    int           n_sent;
    int           n_done;
    int           gap_cnt;
    bit           gapless;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic vec_out_t clamp_vec(vec_in_t v);
        logic [31:0] raw [4];
        logic [31:0] mag [4];
        bit          neg [4];
        logic [67:0] sum;
        logic [32:0] len;
        logic [32:0] cand;
        logic [30:0] bound;
        logic [63:0] q;
        logic [31:0] res [4];
        int          n;
        vec_out_t    r;
        raw[0] = v.comp_x;
        raw[1] = v.comp_y;
        raw[2] = v.comp_z;
        raw[3] = v.comp_w;
        n = (cur_dim < 2) ? 2 : (cur_dim > 4) ? 4 : cur_dim;
        sum = '0;
        for (int i = 0; i < 4; i++)
        begin
            neg[i] = raw[i][31];
            mag[i] = neg[i] ? -raw[i] : raw[i];
            res[i] = '0;
            if (i < n)
                sum = sum + 68'(mag[i]) * 68'(mag[i]);
        end
        len = '0;
        for (int b = 32; b >= 0; b--)
        begin
            cand = len | (33'd1 << b);
            if (68'(cand) * 68'(cand) <= sum)
                len = cand;
        end
        if (len == 0 || (len >= cur_min && len <= cur_max))
        begin
            for (int i = 0; i < n; i++)
                res[i] = raw[i];
        end
        else
        begin
            bound = (len < cur_min) ? cur_min : cur_max;
            for (int i = 0; i < n; i++)
            begin
                q = (64'(mag[i]) * 64'(bound)) / 64'(len);
                if (neg[i])
                begin
                    if (q > 64'h8000_0000)
                        q = 64'h8000_0000;
                    res[i] = -q[31:0];
                end
                else
                begin
                    if (q > 64'h7FFF_FFFF)
                        q = 64'h7FFF_FFFF;
                    res[i] = q[31:0];
                end
            end
        end
        r.out_x = res[0];
        r.out_y = res[1];
        r.out_z = res[2];
        r.out_w = res[3];
        return r;
    endfunction

    // driver: hold the item while busy, advance once accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start   <= 1'b0;
            operand <= '0;
            gap_cnt <= 0;
        end
        else
        begin
            if (start && !busy)
                expected_vecs.push_back(clamp_vec(operand));
            if (!(start && busy))
            begin
                if (gap_cnt > 0)
                begin
                    gap_cnt <= gap_cnt - 1;
                    start   <= 1'b0;
                end
                else if (pending_vecs.size() > 0)
                begin
                    operand <= pending_vecs.pop_front();
                    start   <= 1'b1;
                    gap_cnt <= gapless ? 0 :
                               ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor: every strobed transaction against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            n_done = n_done + 1;
            if (expected_vecs.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, result);
                errors = errors + 1;
            end
            else
            begin
                vec_out_t e;
                e = expected_vecs.pop_front();
                if (e.out_x !== result.out_x)
                    $display("%0t: out_x expected %h actual %h", $time, e.out_x, result.out_x);
                if (e.out_y !== result.out_y)
                    $display("%0t: out_y expected %h actual %h", $time, e.out_y, result.out_y);
                if (e.out_z !== result.out_z)
                    $display("%0t: out_z expected %h actual %h", $time, e.out_z, result.out_z);
                if (e.out_w !== result.out_w)
                    $display("%0t: out_w expected %h actual %h", $time, e.out_w, result.out_w);
                if (e !== result)
                    errors = errors + 1;
            end
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx) << 2;
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_DIMENSION:  cur_dim = val[2:0];
            REG_MIN_LENGTH: cur_min = val[30:0];
            REG_MAX_LENGTH: cur_max = val[30:0];
            default: ;
        endcase
    endtask

    task automatic set_bounds(input logic [31:0] d, input logic [31:0] lo, input logic [31:0] hi);
        reg_write(REG_DIMENSION, d);
        reg_write(REG_MIN_LENGTH, lo);
        reg_write(REG_MAX_LENGTH, hi);
    endtask

    task automatic drain();
        while (n_done < n_sent)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $signed($urandom) >>> $urandom_range(0, 31);
            2: return $signed($urandom) >>> $urandom_range(8, 20);
            3: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            4: return 32'h0;
            default: return $signed($urandom) >>> $urandom_range(12, 16);
        endcase
    endfunction

    task automatic queue_vec(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z, input logic [31:0] w);
        vec_in_t v;
        v.comp_x = x;
        v.comp_y = y;
        v.comp_z = z;
        v.comp_w = w;
        pending_vecs.push_back(v);
        n_sent = n_sent + 1;
    endtask

    task automatic random_phase(input int count);
        gapless = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < count; i++)
            queue_vec(rand_comp(), rand_comp(), rand_comp(), rand_comp());
        drain();
    endtask

    initial
    begin
        errors  = 0;
        n_sent  = 0;
        n_done  = 0;
        gapless = 1'b0;
        cur_dim = DIMENSION_RESET;
        cur_min = MIN_RESET;
        cur_max = MAX_RESET;
        rst_n   = 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: extremes and zero length
        queue_vec(32'h0, 32'h0, 32'h0, 32'h0);
        queue_vec(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        queue_vec(32'h0001_0000, 32'hFFFF_0000, 32'h0, 32'h1);
        drain();

        set_bounds(2, 32'h0002_0000, 32'h0004_0000);
        queue_vec(32'h0000_8000, 32'h0, 32'h1234_5678, 32'h1);
        queue_vec(32'h0003_0000, 32'hFFFF_0000, 32'h0, 32'h0);
        queue_vec(32'h0010_0000, 32'hFFF0_0000, 32'h7, 32'h7);
        queue_vec(32'h8000_0000, 32'h0, 32'h0, 32'h0);
        queue_vec(32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain();

        set_bounds(3, 32'hFFFF_FFFF, 32'h0);
        queue_vec(32'h1, 32'h0, 32'h0, 32'h0);
        queue_vec(32'hFFFF_FFFF, 32'h1, 32'h1, 32'h5);
        queue_vec(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
        queue_vec(32'h0, 32'h0, 32'h0, 32'h0);
        drain();

        set_bounds(0, 32'h0001_0000, 32'h0000_8000);
        queue_vec(32'h0000_4000, 32'h0000_4000, 32'h0, 32'h0);
        queue_vec(32'h0000_C000, 32'h0, 32'h0, 32'h0);
        queue_vec(32'h4000_0000, 32'hC000_0000, 32'h1, 32'h1);
        drain();

        set_bounds(7, 32'h0, 32'h1);
        queue_vec(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_vec(32'h0, 32'h1, 32'h0, 32'h0);
        queue_vec(32'h2, 32'h0, 32'h0, 32'hFFFF_FFFE);
        drain();

        set_bounds(4, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        random_phase(80);
        set_bounds(2, 32'h0001_0000, 32'h0100_0000);
        random_phase(90);
        set_bounds(3, 32'h0100_0000, 32'h0400_0000);
        random_phase(90);
        set_bounds(1, 32'h0, 32'h0000_0001);
        random_phase(60);
        set_bounds(5, 32'h4000_0000, 32'h0000_1000);
        random_phase(60);
        for (int p = 0; p < 5; p++)
        begin
            set_bounds($urandom_range(0, 7), $urandom >> $urandom_range(0, 31),
                       $urandom >> $urandom_range(0, 31));
            random_phase(70);
        end
        set_bounds(4, 32'h0, 32'h7FFF_FFFF);
        random_phase(20);

        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb NOT OK");
        $finish;
    end

endmodule

>>> files.f
rtl/core/vmc_pkg.sv
rtl/core/vmc_front.sv
rtl/core/vmc_queue.sv
rtl/core/vmc_div.sv
rtl/core/vmc_back.sv
rtl/core/vector_magnitude_clamp_top.sv
rtl/core/vmc_checker.sv
tb/tb.sv
